// ----- hw/rtl/frustum_box_cull_top_assert.svh -----
// Assertion macros for the frustum box cull block.
`ifndef FRUSTUM_BOX_CULL_TOP_ASSERT_SVH
`define FRUSTUM_BOX_CULL_TOP_ASSERT_SVH

// same-cycle implication
`define FBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/fbc_pkg.sv -----
// Types and constants shared by the frustum box cull block.
`default_nettype none
package fbc_pkg;

  localparam int CORNERS_PER_BOX = 8;
  localparam int FRAC_BITS       = 16;
  localparam int NUM_PLANES      = 6;
  localparam int CNT_W           = $clog2(CORNERS_PER_BOX + 1);

  localparam int MAT_TERMS   = 64;
  localparam int PLN_TERMS   = NUM_PLANES * 4 * 2;
  localparam int BOX_TERMS   = NUM_PLANES * 4;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'(64'd1 << FRAC_BITS);

  localparam logic [2:0] PL_LEFT   = 3'd0;
  localparam logic [2:0] PL_RIGHT  = 3'd1;
  localparam logic [2:0] PL_TOP    = 3'd2;
  localparam logic [2:0] PL_BOTTOM = 3'd3;
  localparam logic [2:0] PL_NEAR   = 3'd4;
  localparam logic [2:0] PL_FAR    = 3'd5;

  localparam logic [1:0] COL_X = 2'd0;
  localparam logic [1:0] COL_Y = 2'd1;
  localparam logic [1:0] COL_Z = 2'd2;
  localparam logic [1:0] COL_W = 2'd3;

  typedef enum logic [1:0] {
    CMD_VIEW    = 2'd0,
    CMD_PROJ    = 2'd1,
    CMD_EXTRACT = 2'd2,
    CMD_CORNER  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATMUL,
    ST_MAT_DRAIN,
    ST_PLANES,
    ST_PLN_DRAIN,
    ST_CORNER,
    ST_BOX_DRAIN
  } state_t;

  typedef enum logic [1:0] {
    DST_MAT,
    DST_PLANE,
    DST_HIT
  } dest_t;

  typedef struct packed {
    logic       vld;
    logic       first;
    logic       last;
    logic       sub;
    dest_t      dst;
    logic [4:0] idx;
  } tag_t;

endpackage
`default_nettype wire

// ----- hw/rtl/frustum_box_cull_top.sv -----
// Frustum plane extraction and box culling on one shared multiply-accumulate pipeline.
//
//  channel  dir  payload
//  in_      in   tuser: command; tdata: row, col, element, corner_x, corner_y, corner_z
//  out_     out  tdata: visible (one transfer after each full box)
//
// Load commands leave in_tready high. After a corner transfer in_tready is low while 24
// plane terms are issued one per cycle into the shared 32x32 multiplier, drain through the
// 3 pipeline stages and the box wraps up, so no new corner is taken before the last is done.
// After an extract transfer in_tready is low while 64 matrix terms and 48 plane terms are
// issued, each set followed by a pipeline drain. The eighth corner waits in wrap-up while a
// result is still pending. Synchronous active-low reset clears control state only.
`default_nettype none
module frustum_box_cull_top
  import fbc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [135:0] in_tdata,  // row, col, element, corner_x, corner_y, corner_z
  input  wire logic [1:0]   in_tuser,  // command
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [7:0]        out_tdata  // visible
);

  state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  logic [31:0] view_r  [16];
  logic [31:0] proj_r  [16];
  logic [31:0] mat_r   [16];
  logic [31:0] plane_r [24];

  logic [31:0] cx_r, cy_r, cz_r;
  logic [NUM_PLANES-1:0] hit_r;
  logic [CNT_W-1:0] corner_cnt_r;
  logic [CNT_W-1:0] corner_inc;
  logic out_tvalid_r, vis_r;

  logic [31:0] opa_r, opb_r, opa_nxt, opb_nxt;
  tag_t tag0_r, tag1_r, tag2_r, tag0_nxt;
  logic [63:0] prod_r;
  logic [31:0] q_r, q_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [63:0] shifted;
  logic [33:0] sum;

  logic in_xfer, pipe_empty, out_free, box_done, finish_box;
  cmd_t cmd;
  logic [1:0] row, col;
  logic [31:0] element;

  assign cmd     = cmd_t'(in_tuser);
  assign row     = in_tdata[1:0];
  assign col     = in_tdata[3:2];
  assign element = in_tdata[35:4];

  assign in_xfer    = in_tvalid && in_tready;
  assign pipe_empty = !tag0_r.vld && !tag1_r.vld && !tag2_r.vld;
  assign out_free   = !out_tvalid_r || out_tready;
  assign corner_inc = corner_cnt_r + CNT_W'(1);
  assign box_done   = (corner_inc == CNT_W'(CORNERS_PER_BOX));
  assign finish_box = (state_r == ST_BOX_DRAIN) && pipe_empty && (out_free || !box_done);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cnt_nxt   = '0;
        if (in_tvalid) begin
          if (cmd == CMD_EXTRACT) begin
            state_nxt = ST_MATMUL;
          end else if (cmd == CMD_CORNER) begin
            state_nxt = ST_CORNER;
          end
        end
      end
      ST_MATMUL: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(MAT_TERMS - 1)) begin
          state_nxt = ST_MAT_DRAIN;
        end
      end
      ST_MAT_DRAIN: begin
        cnt_nxt = '0;
        if (pipe_empty) begin
          state_nxt = ST_PLANES;
        end
      end
      ST_PLANES: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(PLN_TERMS - 1)) begin
          state_nxt = ST_PLN_DRAIN;
        end
      end
      ST_PLN_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CORNER: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(BOX_TERMS - 1)) begin
          state_nxt = ST_BOX_DRAIN;
        end
      end
      ST_BOX_DRAIN: begin
        if (finish_box) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // term issue: operand select
  always_comb begin
    logic [4:0] e;
    logic [2:0] p;
    logic [1:0] r;
    e        = cnt_r[5:1];
    p        = e[4:2];
    r        = e[1:0];
    opa_nxt  = '0;
    opb_nxt  = Q_ONE;
    tag0_nxt = '0;
    unique case (state_r)
      ST_MATMUL: begin
        opa_nxt        = view_r[{cnt_r[5:4], cnt_r[1:0]}];
        opb_nxt        = proj_r[{cnt_r[1:0], cnt_r[3:2]}];
        tag0_nxt.vld   = 1'b1;
        tag0_nxt.first = (cnt_r[1:0] == 2'd0);
        tag0_nxt.last  = (cnt_r[1:0] == 2'd3);
        tag0_nxt.dst   = DST_MAT;
        tag0_nxt.idx   = {1'b0, cnt_r[5:2]};
      end
      ST_PLANES: begin
        tag0_nxt.vld = 1'b1;
        tag0_nxt.dst = DST_PLANE;
        tag0_nxt.idx = e;
        if (!cnt_r[0]) begin
          tag0_nxt.first = 1'b1;
          opa_nxt = (p == PL_NEAR) ? mat_r[{r, COL_Z}] : mat_r[{r, COL_W}];
        end else begin
          tag0_nxt.last = 1'b1;
          unique case (p)
            PL_LEFT:   opa_nxt = mat_r[{r, COL_X}];
            PL_RIGHT:  begin opa_nxt = mat_r[{r, COL_X}]; tag0_nxt.sub = 1'b1; end
            PL_TOP:    begin opa_nxt = mat_r[{r, COL_Y}]; tag0_nxt.sub = 1'b1; end
            PL_BOTTOM: opa_nxt = mat_r[{r, COL_Y}];
            PL_FAR:    begin opa_nxt = mat_r[{r, COL_Z}]; tag0_nxt.sub = 1'b1; end
            default:   opa_nxt = '0;
          endcase
        end
      end
      ST_CORNER: begin
        opa_nxt        = plane_r[cnt_r[4:0]];
        tag0_nxt.vld   = 1'b1;
        tag0_nxt.first = (cnt_r[1:0] == 2'd0);
        tag0_nxt.last  = (cnt_r[1:0] == 2'd3);
        tag0_nxt.dst   = DST_HIT;
        tag0_nxt.idx   = {2'b00, cnt_r[4:2]};
        unique case (cnt_r[1:0])
          2'd0:    opb_nxt = cx_r;
          2'd1:    opb_nxt = cy_r;
          2'd2:    opb_nxt = cz_r;
          default: opb_nxt = Q_ONE;
        endcase
      end
      default: ;
    endcase
  end

  // product scale and saturate, then saturating accumulate
  always_comb begin
    shifted = 64'($signed(prod_r) >>> FRAC_BITS);
    if ((&shifted[63:31]) || !(|shifted[63:31])) begin
      q_nxt = shifted[31:0];
    end else begin
      q_nxt = shifted[63] ? Q_MIN : Q_MAX;
    end
    if (tag2_r.sub) begin
      sum = {{2{acc_r[31]}}, acc_r} - {{2{q_r[31]}}, q_r};
    end else begin
      sum = {{2{acc_r[31]}}, acc_r} + {{2{q_r[31]}}, q_r};
    end
    if (tag2_r.first) begin
      acc_nxt = q_r;
    end else if ((&sum[33:31]) || !(|sum[33:31])) begin
      acc_nxt = sum[31:0];
    end else begin
      acc_nxt = sum[33] ? Q_MIN : Q_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      tag0_r       <= '0;
      tag1_r       <= '0;
      tag2_r       <= '0;
      hit_r        <= '0;
      corner_cnt_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      tag0_r  <= tag0_nxt;
      tag1_r  <= tag0_r;
      tag2_r  <= tag1_r;
      if (finish_box && box_done) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (in_xfer && cmd == CMD_EXTRACT) begin
        hit_r        <= '0;
        corner_cnt_r <= '0;
      end else if (tag2_r.vld && tag2_r.last && tag2_r.dst == DST_HIT &&
                   !acc_nxt[31] && (|acc_nxt)) begin
        hit_r[tag2_r.idx[2:0]] <= 1'b1;
      end else if (finish_box) begin
        if (box_done) begin
          hit_r        <= '0;
          corner_cnt_r <= '0;
        end else begin
          corner_cnt_r <= corner_inc;
        end
      end
    end
  end

  // datapath and stores
  always_ff @(posedge clk) begin
    opa_r  <= opa_nxt;
    opb_r  <= opb_nxt;
    prod_r <= $signed(opa_r) * $signed(opb_r);
    q_r    <= q_nxt;
    if (tag2_r.vld) begin
      acc_r <= acc_nxt;
    end
    if (in_xfer && cmd == CMD_VIEW) begin
      view_r[{row, col}] <= element;
    end
    if (in_xfer && cmd == CMD_PROJ) begin
      proj_r[{row, col}] <= element;
    end
    if (in_xfer && cmd == CMD_CORNER) begin
      cx_r <= in_tdata[67:36];
      cy_r <= in_tdata[99:68];
      cz_r <= in_tdata[131:100];
    end
    if (tag2_r.vld && tag2_r.last && tag2_r.dst == DST_MAT) begin
      mat_r[tag2_r.idx[3:0]] <= acc_nxt;
    end
    if (tag2_r.vld && tag2_r.last && tag2_r.dst == DST_PLANE) begin
      plane_r[tag2_r.idx] <= acc_nxt;
    end
    if (finish_box && box_done) begin
      vis_r <= &hit_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, vis_r};

`include "frustum_box_cull_top_assert.svh"

  `FBC_ASSERT_NOW(a_ready_pipe_empty, in_tready, pipe_empty, "ready while terms in flight")
  `FBC_ASSERT_NEXT(a_corner_starts, in_xfer && cmd == CMD_CORNER,
                   state_r == ST_CORNER && cnt_r == 6'd0, "corner did not start sweep")
  `FBC_ASSERT_NOW(a_hit_in_box, tag2_r.vld && tag2_r.dst == DST_HIT,
                  state_r == ST_CORNER || state_r == ST_BOX_DRAIN, "plane test outside a corner")

endmodule
`default_nettype wire

// ----- tb/frustum_box_cull_top_tb.sv -----
// Self-checking testbench for frustum_box_cull_top: stream stimulus, plane/box predictor, checker.
`timescale 1ns / 1ps
module frustum_box_cull_top_tb;
  import fbc_pkg::*;

  localparam int RESET_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int TAIL_ITEMS     = 150;
  localparam int DRAIN_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    cmd_t               cmd;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] element;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
  } cull_item_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;  // row, col, element, corner_x, corner_y, corner_z
  logic [1:0]   in_tuser = CMD_VIEW;  // command
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;  // visible

  frustum_box_cull_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cull_item_t pending_items[$];
  cull_item_t held_item;
  logic       expected_visible[$];
  int         mismatch_count = 0;
  int         in_gap = 0;
  int         out_gap = 0;
  int         quiet_cycles = 0;
  logic       quiet_tail = 1'b0;

  // predictor state
  logic signed [31:0] view_elem[16];
  logic signed [31:0] proj_elem[16];
  logic signed [31:0] plane_coef[24];
  logic [5:0]         plane_hits = '0;
  int                 box_corners = 0;

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Q16.16 helpers: saturate, floor-shifted product, saturated sum
  function automatic logic signed [31:0] clamp_q(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    longint prod;
    prod = longint'(a) * longint'(b);
    return clamp_q(prod >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] fx_add(input longint a, input longint b);
    return clamp_q(a + b);
  endfunction

  task automatic frustum_step(input cull_item_t it);
    logic signed [31:0] prod_m[4][4];
    logic signed [31:0] acc;
    logic signed [31:0] sum;
    int base;
    case (it.cmd)
      CMD_VIEW: view_elem[{it.row, it.col}] = it.element;
      CMD_PROJ: proj_elem[{it.row, it.col}] = it.element;
      CMD_EXTRACT: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            acc = '0;
            for (int k = 0; k < 4; k++)
              acc = fx_add(acc, fx_mul(view_elem[r*4+k], proj_elem[k*4+c]));
            prod_m[r][c] = acc;
          end
        end
        for (int r = 0; r < 4; r++) begin
          plane_coef[int'(PL_LEFT)*4+r]   = fx_add(prod_m[r][COL_W], prod_m[r][COL_X]);
          plane_coef[int'(PL_RIGHT)*4+r]  = fx_add(prod_m[r][COL_W], -longint'(prod_m[r][COL_X]));
          plane_coef[int'(PL_TOP)*4+r]    = fx_add(prod_m[r][COL_W], -longint'(prod_m[r][COL_Y]));
          plane_coef[int'(PL_BOTTOM)*4+r] = fx_add(prod_m[r][COL_W], prod_m[r][COL_Y]);
          plane_coef[int'(PL_NEAR)*4+r]   = prod_m[r][COL_Z];
          plane_coef[int'(PL_FAR)*4+r]    = fx_add(prod_m[r][COL_W], -longint'(prod_m[r][COL_Z]));
        end
        plane_hits = '0;
        box_corners = 0;
      end
      CMD_CORNER: begin
        for (int p = 0; p < NUM_PLANES; p++) begin
          base = p * 4;
          sum = fx_add(fx_mul(plane_coef[base], it.cx), fx_mul(plane_coef[base+1], it.cy));
          sum = fx_add(sum, fx_mul(plane_coef[base+2], it.cz));
          sum = fx_add(sum, plane_coef[base+3]);
          if (sum > 0) plane_hits[p] = 1'b1;
        end
        box_corners++;
        if (box_corners >= CORNERS_PER_BOX) begin
          expected_visible.push_back(&plane_hits);
          plane_hits = '0;
          box_corners = 0;
        end
      end
    endcase
  endtask

  // stimulus helpers
  function automatic logic signed [31:0] q8(input int eighths);
    return eighths * 8192;
  endfunction

  function automatic logic signed [31:0] wild_word();
    case ($urandom_range(0, 3))
      0: return Q_MAX;
      1: return Q_MIN;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(input cmd_t cmd, input logic [1:0] row, input logic [1:0] col,
                          input logic signed [31:0] element, input logic signed [31:0] cx,
                          input logic signed [31:0] cy, input logic signed [31:0] cz);
    cull_item_t it;
    it.cmd = cmd;
    it.row = row;
    it.col = col;
    it.element = element;
    it.cx = cx;
    it.cy = cy;
    it.cz = cz;
    pending_items.push_back(it);
  endtask

  task automatic add_load(input cmd_t cmd, input int row, input int col,
                          input logic signed [31:0] v);
    add_item(cmd, row[1:0], col[1:0], v, $urandom, $urandom, $urandom);
  endtask

  task automatic add_extract();
    add_item(CMD_EXTRACT, 2'($urandom), 2'($urandom), $urandom, $urandom, $urandom, $urandom);
  endtask

  // view: identity plus translation row; proj: scale x/y, z -> (a*z + b, z)
  task automatic add_frustum(input int sx8, input int sy8, input int a8, input int b8,
                             input int tx8, input int ty8, input int tz8);
    logic signed [31:0] v;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        v = (r == c) ? Q_ONE : '0;
        if (r == 3 && c == 0) v = q8(tx8);
        if (r == 3 && c == 1) v = q8(ty8);
        if (r == 3 && c == 2) v = q8(tz8);
        add_load(CMD_VIEW, r, c, v);
      end
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        v = '0;
        if (r == 0 && c == 0) v = q8(sx8);
        if (r == 1 && c == 1) v = q8(sy8);
        if (r == 2 && c == 2) v = q8(a8);
        if (r == 2 && c == 3) v = Q_ONE;
        if (r == 3 && c == 2) v = q8(b8);
        add_load(CMD_PROJ, r, c, v);
      end
    end
  endtask

  task automatic add_box(input logic signed [31:0] x0, input logic signed [31:0] x1,
                         input logic signed [31:0] y0, input logic signed [31:0] y1,
                         input logic signed [31:0] z0, input logic signed [31:0] z1,
                         input int count, input bit wild);
    logic signed [31:0] x, y, z;
    for (int i = 0; i < count; i++) begin
      x = i[0] ? x1 : x0;
      y = i[1] ? y1 : y0;
      z = i[2] ? z1 : z0;
      if (wild && $urandom_range(0, 9) == 0) begin
        x = wild_word();
        y = wild_word();
        z = wild_word();
      end
      add_item(CMD_CORNER, 2'($urandom), 2'($urandom), $urandom, x, y, z);
    end
  endtask

  task automatic add_random_box(input int count);
    int cx8, cy8, cz8, h8;
    cx8 = int'($urandom_range(0, 128)) - 64;
    cy8 = int'($urandom_range(0, 128)) - 64;
    cz8 = int'($urandom_range(0, 128)) - 32;
    h8  = $urandom_range(0, 16);
    add_box(q8(cx8 - h8), q8(cx8 + h8), q8(cy8 - h8), q8(cy8 + h8),
            q8(cz8 - h8), q8(cz8 + h8), count, $urandom_range(0, 4) == 0);
  endtask

  initial begin
    int sel, n;
    // directed: frustum between z = 1 and z = 9, |x|,|y| < z
    add_frustum(8, 8, 9, -9, 0, 0, 0);
    add_extract();
    add_box(q8(-4), q8(4), q8(-4), q8(4), q8(36), q8(44), 8, 1'b0);
    add_box(q8(-4), q8(4), q8(-4), q8(4), q8(-44), q8(-36), 8, 1'b0);
    add_box(q8(160), q8(168), q8(-4), q8(4), q8(36), q8(44), 8, 1'b0);
    add_box(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 8, 1'b0);
    // partial box dropped by an extract
    add_box(q8(-4), q8(4), q8(-4), q8(4), q8(36), q8(44), 3, 1'b0);
    add_extract();
    add_box(q8(-4), q8(4), q8(-4), q8(4), q8(36), q8(44), 8, 1'b0);
    // saturating matrix elements
    add_load(CMD_VIEW, 0, 0, Q_MAX);
    add_load(CMD_PROJ, 0, 0, Q_MIN);
    add_load(CMD_VIEW, 3, 3, Q_MIN);
    add_load(CMD_PROJ, 3, 3, Q_MAX);
    add_extract();
    add_box(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 8, 1'b0);
    add_box(q8(-4), q8(4), q8(-4), q8(4), q8(36), q8(44), 8, 1'b0);

    // random: mostly whole boxes, some reloads, broken boxes and noise
    n = pending_items.size();
    add_frustum(8, 8, 9, -9, 0, 0, 0);
    add_extract();
    while (pending_items.size() < n + RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        add_frustum($urandom_range(4, 16), $urandom_range(4, 16), $urandom_range(8, 16),
                    -int'($urandom_range(0, 32)), int'($urandom_range(0, 32)) - 16,
                    int'($urandom_range(0, 32)) - 16, int'($urandom_range(0, 32)) - 16);
        add_extract();
      end else if (sel < 10) begin
        repeat ($urandom_range(1, 4))
          add_load($urandom_range(0, 1) ? CMD_PROJ : CMD_VIEW, $urandom_range(0, 3),
                   $urandom_range(0, 3),
                   $urandom_range(0, 1) ? wild_word() : q8(int'($urandom_range(0, 32)) - 16));
        add_extract();
      end else if (sel < 15) begin
        repeat ($urandom_range(1, 3))
          add_item(cmd_t'($urandom_range(0, 3)), 2'($urandom), 2'($urandom), $urandom,
                   $urandom, $urandom, $urandom);
      end else if (sel < 20) begin
        add_random_box($urandom_range(1, CORNERS_PER_BOX - 1));
      end else begin
        add_random_box(CORNERS_PER_BOX);
      end
    end
  end

  // input driver
  always @(posedge clk) begin
    logic next_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        frustum_step(held_item);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() > 0) begin
          if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            in_gap = $urandom_range(1, 12) - 1;
          end else begin
            held_item = pending_items.pop_front();
            next_valid = 1'b1;
          end
        end
      end
      quiet_tail <= pending_items.size() < TAIL_ITEMS;
      in_tvalid <= next_valid;
      if (next_valid) begin
        in_tdata <= {4'b0, held_item.cz, held_item.cy, held_item.cx, held_item.element,
                     held_item.col, held_item.row};
        in_tuser <= held_item.cmd;
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    logic want;
    logic next_ready;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_visible.size() == 0) begin
          flag_mismatch($sformatf("unexpected result visible=%0b", out_tdata[0]));
        end else begin
          want = expected_visible.pop_front();
          if (out_tdata[0] !== want)
            flag_mismatch($sformatf("visible got %b exp %b", out_tdata[0], want));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        next_ready = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(1, 12) - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_tready <= next_ready;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("[%0t] watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_visible.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
